[rtl/efg_pkg.sv]
`default_nettype none

package efg_pkg;

	// fixed field widths
	localparam int FLAG_W = 16;
	localparam int SLOT_W = 3;

	// default slot count and most results reported for one set beat
	localparam int WAITERS_DEF = 8;
	localparam int RESULT_CAP = 8;

	// wait mode bits: bit 0 selects any, bit 1 selects clear on release
	localparam int MODE_ANY_BIT = 0;
	localparam int MODE_CLR_BIT = 1;

	typedef enum logic [1:0] {
		KIND_WAIT   = 2'd0,
		KIND_SET    = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_EXPIRE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_MATCHED  = 3'd0,
		ST_BLOCKED  = 3'd1,
		ST_RELEASED = 3'd2,
		ST_EXPIRED  = 3'd3,
		ST_DONE     = 3'd4,
		ST_SLOTERR  = 3'd5
	} status_t;

	// one waiter slot entry as held in the slot memory
	typedef struct packed {
		logic [1:0]        mode;
		logic [FLAG_W-1:0] mask;
	} slot_ent_t;

endpackage

`default_nettype wire

[rtl/efg_slot_mem.sv]
`default_nettype none

module efg_slot_mem
	import efg_pkg::*;
#(
	parameter int DEPTH = WAITERS_DEF,
	parameter int AW    = 3
) (
	input  wire logic      clk,
	input  wire logic      we,
	input  wire logic [AW-1:0] waddr,
	input  wire slot_ent_t wdata,
	input  wire logic [AW-1:0] raddr,
	output slot_ent_t      rdata
);

	slot_ent_t mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/efg_ctrl.sv]
`default_nettype none

module efg_ctrl
	import efg_pkg::*;
#(
	parameter int WAITERS = WAITERS_DEF,
	parameter int IW      = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        kind,
	input  wire logic [FLAG_W-1:0] flag_mask,
	input  wire logic [1:0]        wait_mode,
	input  wire logic [SLOT_W-1:0] waiter,
	output logic                   strobe,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      waiter_out,
	output logic [FLAG_W-1:0]      result_mask,
	output logic [FLAG_W-1:0]      flags_now,
	output logic                   last,
	// slot memory
	output logic                   mem_we,
	output logic [IW-1:0]          mem_waddr,
	output slot_ent_t              mem_wdata,
	output logic [IW-1:0]          mem_raddr,
	input  wire slot_ent_t         mem_rdata
);

	localparam int CW = $clog2(WAITERS + 1);
	localparam int RW = $clog2(RESULT_CAP + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [FLAG_W-1:0]   flags_q;
	logic [WAITERS-1:0]  valid_q;
	logic [WAITERS-1:0]  rel_q;
	logic [FLAG_W-1:0]   set_mask_q;
	logic [FLAG_W-1:0]   comb_q;
	logic [FLAG_W-1:0]   next_q;
	logic [CW-1:0]       rel_cnt_q;
	logic [RW-1:0]       total_q;
	logic [RW-1:0]       rep_cnt_q;
	logic [CW-1:0]       cnt_q;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;

	logic                strobe_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   waiter_q;
	logic [FLAG_W-1:0]   rmask_q;
	logic [FLAG_W-1:0]   fnow_q;
	logic                last_q;

	// input beat decode
	kind_t               kind_in;
	logic                accept;
	logic [IW-1:0]       sidx;
	logic                slot_ok;
	logic                slot_busy;
	logic [FLAG_W-1:0]   w_hit;
	logic                w_all_ok;
	logic                w_any_ok;

	// scan stage
	logic                issue;
	logic                e_match;
	logic [FLAG_W-1:0]   e_hit;
	logic [FLAG_W-1:0]   e_got;
	logic                scan_rel;
	logic [FLAG_W-1:0]   clr_now;
	logic [FLAG_W-1:0]   next_d;
	logic [CW-1:0]       rel_cnt_d;
	logic                scan_end;
	logic                emit_last;

	assign busy        = (state_q != S_IDLE);
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign waiter_out  = waiter_q;
	assign result_mask = rmask_q;
	assign flags_now   = fnow_q;
	assign last        = last_q;

	// decode of an accepted beat
	always_comb begin
		kind_in   = kind_t'(kind);
		accept    = start && (state_q == S_IDLE);
		sidx      = IW'(waiter);
		slot_ok   = (int'(waiter) < WAITERS);
		slot_busy = valid_q[sidx];
		w_hit     = flags_q & flag_mask;
		w_all_ok  = !wait_mode[MODE_ANY_BIT] && (w_hit == flag_mask);
		w_any_ok  = wait_mode[MODE_ANY_BIT] && (w_hit != '0);
	end

	// slot memory write on a blocking wait, reads walk the slots
	always_comb begin
		mem_we    = accept && (kind_in == KIND_WAIT) && slot_ok && !slot_busy
			&& !w_all_ok && !w_any_ok;
		mem_waddr = sidx;
		mem_wdata = '{mode: wait_mode, mask: flag_mask};
		mem_raddr = cnt_q[IW-1:0];
	end

	// match check on the entry read back
	always_comb begin
		issue     = (cnt_q < CW'(WAITERS));
		e_hit     = mem_rdata.mask & comb_q;
		if (mem_rdata.mode[MODE_ANY_BIT]) begin
			e_match = (e_hit != '0);
			e_got   = e_hit;
		end else begin
			e_match = (e_hit == mem_rdata.mask);
			e_got   = mem_rdata.mask;
		end
		scan_rel  = (state_q == S_SCAN) && vld_s1 && valid_q[idx_s1] && e_match;
		clr_now   = (scan_rel && mem_rdata.mode[MODE_CLR_BIT]) ?
			(mem_rdata.mask & set_mask_q) : '0;
		next_d    = next_q & ~clr_now;
		rel_cnt_d = rel_cnt_q + CW'(scan_rel);
		scan_end  = vld_s1 && (idx_s1 == IW'(WAITERS - 1));
		emit_last = ((rep_cnt_q + RW'(1)) == total_q);
	end

	// sequencer, state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			flags_q   <= '0;
			valid_q   <= '0;
			rel_q     <= '0;
			rel_cnt_q <= '0;
			total_q   <= '0;
			rep_cnt_q <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			idx_s1    <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			vld_s1   <= 1'b0;
			idx_s1   <= cnt_q[IW-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						waiter_q <= waiter;
						rmask_q  <= '0;
						fnow_q   <= flags_q;
						last_q   <= 1'b1;
						unique case (kind_in)
							KIND_WAIT: begin
								strobe_q <= 1'b1;
								if (!slot_ok || slot_busy) begin
									status_q <= ST_SLOTERR;
								end else if (w_all_ok) begin
									status_q <= ST_MATCHED;
									rmask_q  <= flag_mask;
								end else if (w_any_ok) begin
									status_q <= ST_MATCHED;
									rmask_q  <= w_hit;
								end else begin
									status_q      <= ST_BLOCKED;
									valid_q[sidx] <= 1'b1;
								end
							end
							KIND_SET: begin
								set_mask_q <= flag_mask;
								comb_q     <= flags_q | flag_mask;
								next_q     <= flags_q | flag_mask;
								rel_q      <= '0;
								rel_cnt_q  <= '0;
								cnt_q      <= '0;
								state_q    <= S_SCAN;
							end
							KIND_CLEAR: begin
								strobe_q <= 1'b1;
								status_q <= ST_DONE;
								waiter_q <= '0;
								flags_q  <= flags_q & ~flag_mask;
								fnow_q   <= flags_q & ~flag_mask;
							end
							KIND_EXPIRE: begin
								strobe_q <= 1'b1;
								if (!slot_ok || !slot_busy) begin
									status_q <= ST_SLOTERR;
								end else begin
									status_q      <= ST_EXPIRED;
									valid_q[sidx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					// walk every slot once, releasing matches against the combined word
					if (issue) begin
						vld_s1 <= 1'b1;
						cnt_q  <= cnt_q + CW'(1);
					end
					if (scan_rel) begin
						valid_q[idx_s1] <= 1'b0;
						rel_q[idx_s1]   <= 1'b1;
					end
					next_q    <= next_d;
					rel_cnt_q <= rel_cnt_d;
					if (scan_end) begin
						flags_q   <= next_d;
						cnt_q     <= '0;
						rep_cnt_q <= '0;
						vld_s1    <= 1'b0;
						total_q   <= (int'(rel_cnt_d) > RESULT_CAP) ?
							RW'(RESULT_CAP) : RW'(rel_cnt_d);
						if (rel_cnt_d == '0) begin
							// nothing released: one done beat
							strobe_q <= 1'b1;
							status_q <= ST_DONE;
							waiter_q <= '0;
							rmask_q  <= '0;
							fnow_q   <= next_d;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					// second walk re-reads released slots and sends one beat each, up to RESULT_CAP
					if (issue) begin
						vld_s1 <= 1'b1;
						cnt_q  <= cnt_q + CW'(1);
					end
					if (vld_s1 && rel_q[idx_s1]) begin
						rel_q[idx_s1] <= 1'b0;
						strobe_q      <= 1'b1;
						status_q      <= ST_RELEASED;
						waiter_q      <= SLOT_W'(idx_s1);
						rmask_q       <= e_got;
						fnow_q        <= flags_q;
						last_q        <= emit_last;
						rep_cnt_q     <= rep_cnt_q + RW'(1);
						if (emit_last) begin
							vld_s1  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/event_flag_group_unit.sv]
`default_nettype none

// channel   | ports                                        | handshake
// ----------+----------------------------------------------+---------------------------
// command   | kind, flag_mask, wait_mode, waiter           | start high, busy low
// result    | status, waiter_out, result_mask, flags_now,  | strobe high, one cycle
//           | last                                         |
//
// wait, clear and expire beats are answered directly: the result beat comes in the cycle after the accept.
// a set beat walks the slot memory once to find releases and update the flag word,
// then sends its done beat when nobody is released; with releases a second walk
// sends one beat per released slot, up to RESULT_CAP beats. both walks go through
// the single read port of the slot memory.
// reset clears the flag word and all slot valid bits at once; no clearing pass.
// the receiver cannot stall; busy stays high until the last beat of a set is out.

module event_flag_group_unit
	import efg_pkg::*;
#(
	parameter int WAITERS = WAITERS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        kind,
	input  wire logic [FLAG_W-1:0] flag_mask,
	input  wire logic [1:0]        wait_mode,
	input  wire logic [SLOT_W-1:0] waiter,
	output logic                   strobe,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      waiter_out,
	output logic [FLAG_W-1:0]      result_mask,
	output logic [FLAG_W-1:0]      flags_now,
	output logic                   last
);

	localparam int IW = (WAITERS > 1) ? $clog2(WAITERS) : 1;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	slot_ent_t     mem_wdata;
	logic [IW-1:0] mem_raddr;
	slot_ent_t     mem_rdata;

	// sequencer with flag word and slot valid bits
	efg_ctrl #(
		.WAITERS (WAITERS),
		.IW      (IW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.flag_mask   (flag_mask),
		.wait_mode   (wait_mode),
		.waiter      (waiter),
		.strobe      (strobe),
		.status      (status),
		.waiter_out  (waiter_out),
		.result_mask (result_mask),
		.flags_now   (flags_now),
		.last        (last),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// waiter mask and mode store
	efg_slot_mem #(
		.DEPTH (WAITERS),
		.AW    (IW)
	) u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

[bench/event_flag_group_unit_test.sv]
`default_nettype none

module event_flag_group_unit_test;
	import efg_pkg::*;

	localparam int SLOTS = WAITERS_DEF;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_BEATS = 146;

	// one result beat as the block should present it
	typedef struct packed {
		status_t           st;
		logic [SLOT_W-1:0] slot;
		logic [FLAG_W-1:0] mask;
		logic [FLAG_W-1:0] flags;
		logic              last;
	} flag_result_t;

	// flag word and waiter table tracker plus queue of expected beats
	class flag_group_scoreboard;
		logic [FLAG_W-1:0] flag_word;
		bit                held[SLOTS];
		logic [FLAG_W-1:0] held_mask[SLOTS];
		logic [1:0]        held_mode[SLOTS];
		flag_result_t      awaited_q[$];
		int                errors;
		int                per_kind[4];
		int                per_status[8];

		function new();
			flag_word = '0;
			foreach (held[i])
				held[i] = 1'b0;
			errors = 0;
			foreach (per_kind[i])
				per_kind[i] = 0;
			foreach (per_status[i])
				per_status[i] = 0;
		endfunction

		function bit slot_held(int i);
			return held[i];
		endfunction

		function int pending_count();
			return awaited_q.size();
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		// work out the beats that one accepted command causes
		function void note_command(kind_t k, logic [FLAG_W-1:0] m, logic [1:0] md,
				logic [SLOT_W-1:0] s);
			flag_result_t      batch[$];
			flag_result_t      b;
			logic [FLAG_W-1:0] hit;
			logic [FLAG_W-1:0] combined;
			logic [FLAG_W-1:0] next_word;
			logic [FLAG_W-1:0] got;
			bit                matched;
			per_kind[int'(k)]++;
			b = '{st: ST_DONE, slot: '0, mask: '0, flags: '0, last: 1'b0};
			case (k)
				KIND_WAIT: begin
					hit = flag_word & m;
					b.slot = s;
					if (held[s]) begin
						b.st = ST_SLOTERR;
					end else if (!md[MODE_ANY_BIT] && hit == m) begin
						// immediate match never clears flags, whatever the mode
						b.st = ST_MATCHED;
						b.mask = m;
					end else if (md[MODE_ANY_BIT] && hit != '0) begin
						b.st = ST_MATCHED;
						b.mask = hit;
					end else begin
						held[s] = 1'b1;
						held_mask[s] = m;
						held_mode[s] = md;
						b.st = ST_BLOCKED;
					end
					batch.push_back(b);
				end
				KIND_SET: begin
					// every waiter sees the word right after the or
					combined = flag_word | m;
					next_word = combined;
					for (int i = 0; i < SLOTS; i++) begin
						if (held[i]) begin
							hit = held_mask[i] & combined;
							if (held_mode[i][MODE_ANY_BIT]) begin
								matched = hit != '0;
								got = hit;
							end else begin
								matched = hit == held_mask[i];
								got = held_mask[i];
							end
							if (matched) begin
								held[i] = 1'b0;
								// only bits asked for and raised by this set go
								if (held_mode[i][MODE_CLR_BIT])
									next_word &= ~(held_mask[i] & m);
								if (batch.size() < RESULT_CAP) begin
									b.st = ST_RELEASED;
									b.slot = SLOT_W'(i);
									b.mask = got;
									batch.push_back(b);
								end
							end
						end
					end
					flag_word = next_word;
					if (batch.size() == 0) begin
						b.st = ST_DONE;
						batch.push_back(b);
					end
				end
				KIND_CLEAR: begin
					flag_word &= ~m;
					batch.push_back(b);
				end
				default: begin
					b.slot = s;
					if (!held[s]) begin
						b.st = ST_SLOTERR;
					end else begin
						held[s] = 1'b0;
						b.st = ST_EXPIRED;
					end
					batch.push_back(b);
				end
			endcase
			// flag word after the whole command, last marks the closing beat
			foreach (batch[j]) begin
				batch[j].flags = flag_word;
				batch[j].last = (j == batch.size() - 1);
				awaited_q.push_back(batch[j]);
			end
		endfunction

		// compare one result beat against the oldest expectation
		task check_result(logic [2:0] st, logic [SLOT_W-1:0] w, logic [FLAG_W-1:0] m,
				logic [FLAG_W-1:0] f, logic l);
			flag_result_t exp_beat;
			string        wrong;
			if (awaited_q.size() == 0) begin
				report($sformatf("unexpected beat status %0d waiter %0d mask %h flags %h",
					st, w, m, f));
				return;
			end
			exp_beat = awaited_q.pop_front();
			per_status[int'(exp_beat.st)]++;
			wrong = "";
			if (st !== exp_beat.st)
				wrong = {wrong, " status"};
			if (w !== exp_beat.slot)
				wrong = {wrong, " waiter_out"};
			if (m !== exp_beat.mask)
				wrong = {wrong, " result_mask"};
			if (f !== exp_beat.flags)
				wrong = {wrong, " flags_now"};
			if (l !== exp_beat.last)
				wrong = {wrong, " last"};
			if (wrong != "")
				report($sformatf("wrong%s: got %0d/%0d/%h/%h/%b want %0d/%0d/%h/%h/%b",
					wrong, st, w, m, f, l, exp_beat.st, exp_beat.slot, exp_beat.mask,
					exp_beat.flags, exp_beat.last));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        kind;
	logic [FLAG_W-1:0] flag_mask;
	logic [1:0]        wait_mode;
	logic [SLOT_W-1:0] waiter;
	logic              strobe;
	logic [2:0]        status;
	logic [SLOT_W-1:0] waiter_out;
	logic [FLAG_W-1:0] result_mask;
	logic [FLAG_W-1:0] flags_now;
	logic              last;

	int                   cycle_count = 0;
	flag_group_scoreboard sb;

	event_flag_group_unit DUT (
		.clk,
		.arst_n,
		.start,
		.busy,
		.kind,
		.flag_mask,
		.wait_mode,
		.waiter,
		.strobe,
		.status,
		.waiter_out,
		.result_mask,
		.flags_now,
		.last
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result beats are taken at the edge that ends their cycle
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result(status, waiter_out, result_mask, flags_now, last);
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// sparse masks dominate so that waits block and sets release
	function automatic logic [FLAG_W-1:0] pick_mask();
		int                r;
		logic [FLAG_W-1:0] m;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			m = $urandom_range(0, 1) ? '1 : '0;
		end else if (r < 4) begin
			m = FLAG_W'($urandom_range(0, 65535));
		end else begin
			m = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
			if ($urandom_range(0, 1))
				m |= FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
		end
		return m;
	endfunction

	// hold a command beat until accepted, then idle for the gap
	task automatic send_beat(kind_t k, logic [FLAG_W-1:0] m, logic [1:0] md,
			logic [SLOT_W-1:0] s, int gap);
		kind <= k;
		flag_mask <= m;
		wait_mode <= md;
		waiter <= s;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(k, m, md, s);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap)
				@(posedge clk);
		end
	endtask

	// random command, mostly aimed at slots where it does real work
	task automatic random_command(int gap);
		int                r;
		kind_t             k;
		logic [SLOT_W-1:0] s;
		logic [SLOT_W-1:0] pool[$];
		r = $urandom_range(0, 99);
		s = SLOT_W'($urandom_range(0, SLOTS - 1));
		if (r < 40)
			k = KIND_WAIT;
		else if (r < 65)
			k = KIND_SET;
		else if (r < 80)
			k = KIND_CLEAR;
		else
			k = KIND_EXPIRE;
		// waits go to free slots, expiries to held ones, apart from some noise
		if ((k == KIND_WAIT || k == KIND_EXPIRE) && $urandom_range(0, 9) < 8) begin
			for (int i = 0; i < SLOTS; i++)
				if (sb.slot_held(i) == (k == KIND_EXPIRE))
					pool.push_back(SLOT_W'(i));
			if (pool.size() != 0)
				s = pool[$urandom_range(0, pool.size() - 1)];
		end
		send_beat(k, pick_mask(), 2'($urandom_range(0, 3)), s, gap);
	endtask

	// stimulus
	initial begin
		bit burst;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_WAIT;
		flag_mask = '0;
		wait_mode = 2'd0;
		waiter = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// set that releases nobody, zero mask waits in all and any modes
		send_beat(KIND_SET, 16'h0000, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_WAIT, 16'h0000, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_WAIT, 16'h0000, 2'd1, 3'd1, pick_gap());
		// expiry of a held slot, then of the now empty slot
		send_beat(KIND_EXPIRE, 16'h0000, 2'd0, 3'd1, pick_gap());
		send_beat(KIND_EXPIRE, 16'h0000, 2'd0, 3'd1, pick_gap());
		// immediate matches in clear modes leave the flags alone
		send_beat(KIND_SET, 16'hFFFF, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_WAIT, 16'hFFFF, 2'd2, 3'd2, pick_gap());
		send_beat(KIND_WAIT, 16'h8000, 2'd3, 3'd3, pick_gap());
		send_beat(KIND_CLEAR, 16'hFFFF, 2'd0, 3'd0, pick_gap());
		// fill every slot with every mode
		send_beat(KIND_WAIT, 16'h0003, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_WAIT, 16'h00F0, 2'd1, 3'd1, pick_gap());
		send_beat(KIND_WAIT, 16'h0F00, 2'd2, 3'd2, pick_gap());
		send_beat(KIND_WAIT, 16'hF000, 2'd3, 3'd3, pick_gap());
		send_beat(KIND_WAIT, 16'h8001, 2'd0, 3'd4, pick_gap());
		send_beat(KIND_WAIT, 16'h0001, 2'd3, 3'd5, pick_gap());
		send_beat(KIND_WAIT, 16'h0002, 2'd2, 3'd6, pick_gap());
		send_beat(KIND_WAIT, 16'h0100, 2'd1, 3'd7, pick_gap());
		// wait on a held slot
		send_beat(KIND_WAIT, 16'h0001, 2'd1, 3'd0, pick_gap());
		// one set releases all eight, clears judged against the combined word
		send_beat(KIND_SET, 16'hFFFF, 2'd0, 3'd0, pick_gap());
		// clear mode keeps bits that were already up before the set
		send_beat(KIND_WAIT, 16'h0F0F, 2'd2, 3'd0, pick_gap());
		send_beat(KIND_SET, 16'h0F03, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_CLEAR, 16'h5555, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_CLEAR, 16'hFFFF, 2'd0, 3'd0, pick_gap());
		send_beat(KIND_EXPIRE, 16'hFFFF, 2'd3, 3'd7, pick_gap());

		// random part with a drained pause now and then and one gapless stretch
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 60 == 59) begin
				start <= 1'b0;
				@(posedge clk);
				while (sb.pending_count() != 0)
					@(posedge clk);
			end
			burst = (n >= 100 && n < 130);
			random_command(burst ? 0 : pick_gap());
		end
		start <= 1'b0;

		// let the last beats out, then a little longer than a full set walk
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (sb.pending_count() != 0)
			sb.report($sformatf("%0d expected beats never arrived", sb.pending_count()));

		$display("covered %0d waits, %0d sets, %0d clears, %0d expiries",
			sb.per_kind[KIND_WAIT], sb.per_kind[KIND_SET], sb.per_kind[KIND_CLEAR],
			sb.per_kind[KIND_EXPIRE]);
		$display("beats: %0d matched, %0d blocked, %0d released, %0d expired, %0d slot errors",
			sb.per_status[ST_MATCHED], sb.per_status[ST_BLOCKED], sb.per_status[ST_RELEASED],
			sb.per_status[ST_EXPIRED], sb.per_status[ST_SLOTERR]);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
